/* src/su3r_pkg.sv */
`default_nettype none
package su3r_pkg;

  localparam int W   = 32;   // word width, signed Q2.30
  localparam int VW  = 42;   // row 1 while the projection is removed
  localparam int AW  = 37;   // projection coefficient
  localparam int PW  = AW + W;
  localparam int ACW = 72;   // accumulator
  localparam int NE  = 6;    // words in one row

  localparam logic [1:0] ROW0 = 2'd0;
  localparam logic [1:0] ROW1 = 2'd1;
  localparam logic [1:0] ROW2 = 2'd2;

  localparam logic signed [W-1:0] WMAX = 32'sh7fffffff;
  localparam logic signed [W-1:0] WMIN = 32'sh80000000;

  typedef logic signed [W-1:0] word_t;

  // one matrix as it travels from the front to the back
  typedef struct packed {
    logic             r0_zero;
    word_t [NE-1:0]   r1;
    word_t [NE-1:0]   r0;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SQRT,
    ST_DLOAD,
    ST_DIV,
    ST_RED,
    ST_EMIT
  } back_state_t;

  typedef enum logic [1:0] {
    MK_SQ,   // squared norm
    MK_PR,   // projection coefficient
    MK_UP,   // remove projection from row 1
    MK_CR    // conjugate cross product
  } mac_kind_t;

  typedef enum logic [1:0] {
    OPA_U,
    OPA_V,
    OPA_AR,
    OPA_AI
  } opa_sel_t;

endpackage
`default_nettype wire

/* src/su3_matrix_reunitarize_core.sv */
// channel   dir  transfer when           payload
// in_*      in   in_tvalid & in_tready   tdata: r0c0_re .. r0c2_im, r1c0_re .. r1c2_im
// out_*     out  out_tvalid & out_tready tdata: col0_re .. col2_im, tuser: row, degenerate,
//                                        tlast: last row
//
// in the back end the bit-serial divider handles each of twelve entries in turn, and the
// root unit takes one root for each of rows 0 and 1
// a matrix whose row 0 is zero skips all arithmetic and goes straight to emitting its rows
// synchronous active-low reset clears the queue, the sequencer and the output valid
// a two-entry queue keeps accepting while the back end works; the output register
// holds a row until it is taken, and the back end waits on each row while it is full
`default_nettype none
module su3_matrix_reunitarize_core import su3r_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [383:0]  in_tdata,   // r0c0_re, r0c0_im, .. r0c2_im, r1c0_re, .. r1c2_im
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [191:0]       out_tdata,  // col0_re, col0_im, col1_re, col1_im, col2_re, col2_im
  output logic [2:0]         out_tuser,  // row_number[1:0], degenerate
  output logic               out_tlast
);

  // front to back hand-off
  logic  item_valid;
  item_t item;
  logic  item_pop;

  // front end: accepts matrices, flags a zero row 0, queues two
  su3r_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  // back end: shared multiplier, root unit and divider under one sequencer
  su3r_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef ASSERT_OFF
  // the last-row mark sits exactly on row 2
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser[1:0] == ROW2)))
    else $error("tlast does not match row number");

  // a degenerate matrix carries only zeros
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (out_tdata == '0))
    else $error("degenerate row with nonzero data");

  // after the last row the next matrix starts at row 0
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (!out_tvalid || out_tuser[1:0] == ROW0))
    else $error("row sequence broken");
`endif

endmodule
`default_nettype wire

/* src/su3r_front.sv */
`default_nettype none
module su3r_front import su3r_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [383:0]  in_tdata,
  output logic               item_valid,
  output item_t              item,
  input  wire logic          item_pop
);

  item_t      mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      wr_item;

  assign in_tready  = (cnt_r != 2'd2);
  assign push       = in_tvalid & in_tready;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = mem_r[rp_r];

  // a zero row 0 needs no arithmetic at all
  always_comb begin
    wr_item.r0      = in_tdata[191:0];
    wr_item.r1      = in_tdata[383:192];
    wr_item.r0_zero = (in_tdata[191:0] == '0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (item_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, item_pop};
    end
  end

endmodule
`default_nettype wire

/* src/su3r_back.sv */
`default_nettype none
module su3r_back import su3r_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          item_valid,
  input  wire item_t         item,
  output logic               item_pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [191:0]       out_tdata,
  output logic [2:0]         out_tuser,
  output logic               out_tlast
);

  localparam logic signed [ACW-1:0] RND28 = 72'sd134217728;
  localparam logic signed [ACW-1:0] RND30 = 72'sd536870912;
  localparam logic signed [ACW-1:0] WMAXA = 72'sd2147483647;
  localparam logic signed [ACW-1:0] WMINA = -72'sd2147483648;

  back_state_t state_r, state_nxt;
  mac_kind_t   kind_r;

  word_t                 u_r [NE];
  logic signed [VW-1:0]  v_r [NE];
  word_t                 w_r [NE];
  logic signed [AW-1:0]  ar_r, ai_r;
  logic                  deg_r;
  logic                  row_sel_r;

  logic [4:0]            step_r;
  logic [1:0]            phase_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [ACW-1:0] acc_r;

  logic [63:0]           sq_op_r;
  logic [33:0]           sq_rem_r;
  logic [31:0]           sq_root_r;
  logic                  sq_dbl_r;
  logic [4:0]            sq_cnt_r;
  logic [32:0]           s_r;

  logic [61:0]           div_num_r;
  logic [33:0]           div_rem_r;
  logic [61:0]           div_q_r;
  logic                  div_neg_r;
  logic [5:0]            div_cnt_r;
  logic [2:0]            k_r;

  logic [1:0]            erow_r;
  logic                  out_valid_r;
  logic [191:0]          out_data_r;
  logic [2:0]            out_user_r;
  logic                  out_last_r;

  // operand selection
  logic [2:0]            u_idx, v_idx;
  opa_sel_t              a_sel;
  logic                  b_from_v;
  logic                  neg;
  logic                  sh2;
  logic [2:0]            pidx;
  logic                  pgrp;
  logic [1:0]            cia, cib, cuc, cvc;
  logic                  cim;
  word_t                 u_rd, v_rdw, row_rd;
  logic signed [VW-1:0]  v_rd;
  logic signed [AW-1:0]  mul_a;
  word_t                 mul_b;
  logic signed [PW-1:0]  mul_p;

  // accumulate and write back
  logic                  grp_start, grp_end, last_step;
  logic signed [ACW-1:0] p_ext, p_sh, term, acc_sum, r28, r30, cval;
  word_t                 cw;
  logic                  n_zero, n_big;

  // square root and divider steps
  logic [35:0]           sq_rem2, sq_trial, sq_diff;
  logic                  sq_ge;
  logic [31:0]           sq_root_nxt;
  logic [33:0]           dv_rem2, dv_diff;
  logic                  dv_ge;
  logic [61:0]           dv_q_nxt;
  word_t                 dv_word;
  logic [31:0]           dl_mag;
  logic [61:0]           dl_num;

  logic                  wide;
  logic                  emit_load;
  logic [191:0]          emit_data;

  assign u_rd   = u_r[u_idx];
  assign v_rd   = v_r[v_idx];
  assign v_rdw  = v_rd[W-1:0];
  assign row_rd = row_sel_r ? v_rdw : u_rd;

  assign pidx = (step_r >= 5'd6) ? 3'(step_r - 5'd6) : step_r[2:0];
  assign pgrp = (step_r >= 5'd6);
  assign cim  = step_r[2];

  always_comb begin
    unique case (step_r[4:3])
      2'd0:    begin cia = 2'd1; cib = 2'd2; end
      2'd1:    begin cia = 2'd2; cib = 2'd0; end
      default: begin cia = 2'd0; cib = 2'd1; end
    endcase
    cuc = step_r[1] ? cib : cia;
    cvc = step_r[1] ? cia : cib;
  end

  // term decoder for the multiply-accumulate sequence
  always_comb begin
    u_idx    = k_r;
    v_idx    = k_r;
    a_sel    = OPA_U;
    b_from_v = 1'b1;
    neg      = 1'b0;
    sh2      = 1'b0;
    if (state_r == ST_MAC) begin
      unique case (kind_r)
        MK_SQ: begin
          u_idx    = step_r[2:0];
          v_idx    = step_r[2:0];
          a_sel    = row_sel_r ? OPA_V : OPA_U;
          b_from_v = row_sel_r;
        end
        MK_PR: begin
          u_idx = {pidx[2:1], pidx[0]};
          v_idx = {pidx[2:1], pidx[0] ^ pgrp};
          neg   = pgrp & pidx[0];
          sh2   = 1'b1;
        end
        MK_UP: begin
          u_idx    = {step_r[3:2], step_r[0] ^ step_r[1]};
          a_sel    = step_r[0] ? OPA_AI : OPA_AR;
          b_from_v = 1'b0;
          neg      = ~step_r[1] & step_r[0];
        end
        default: begin
          u_idx = {cuc, step_r[0]};
          v_idx = {cvc, step_r[0] ^ cim};
          neg   = cim ? step_r[1] : (step_r[0] ^ step_r[1]);
        end
      endcase
    end
  end

  always_comb begin
    case (a_sel)
      OPA_U:   mul_a = {{(AW-W){u_rd[W-1]}}, u_rd};
      OPA_V:   mul_a = {{(AW-W){v_rdw[W-1]}}, v_rdw};
      OPA_AR:  mul_a = ar_r;
      default: mul_a = ai_r;
    endcase
    mul_b = b_from_v ? v_rdw : u_rd;
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    unique case (kind_r)
      MK_SQ: begin
        grp_start = (step_r == 5'd0);
        grp_end   = (step_r == 5'd5);
        last_step = (step_r == 5'd5);
      end
      MK_PR: begin
        grp_start = (step_r == 5'd0) || (step_r == 5'd6);
        grp_end   = (step_r == 5'd5) || (step_r == 5'd11);
        last_step = (step_r == 5'd11);
      end
      MK_UP: begin
        grp_start = ~step_r[0];
        grp_end   = step_r[0];
        last_step = (step_r == 5'd11);
      end
      default: begin
        grp_start = (step_r[1:0] == 2'd0);
        grp_end   = (step_r[1:0] == 2'd3);
        last_step = (step_r == 5'd23);
      end
    endcase
  end

  always_comb begin
    p_ext   = {{(ACW-PW){prod_r[PW-1]}}, prod_r};
    p_sh    = sh2 ? (p_ext >>> 2) : p_ext;
    term    = neg ? -p_sh : p_sh;
    acc_sum = (grp_start ? '0 : acc_r) + term;
    r28     = (acc_r + RND28) >>> 28;
    r30     = (acc_r + RND30) >>> 30;
    cval    = step_r[2] ? -r30 : r30;
    if (cval > WMAXA) begin
      cw = WMAX;
    end else if (cval < WMINA) begin
      cw = WMIN;
    end else begin
      cw = cval[W-1:0];
    end
    n_zero = (acc_r == '0);
    n_big  = |acc_r[ACW-1:62];
  end

  // square root, one root bit from each pair of operand bits
  always_comb begin
    sq_rem2     = {sq_rem_r, sq_op_r[63:62]};
    sq_trial    = {2'b00, sq_root_r, 2'b01};
    sq_ge       = (sq_rem2 >= sq_trial);
    sq_diff     = sq_rem2 - sq_trial;
    sq_root_nxt = {sq_root_r[30:0], sq_ge};
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    dv_rem2  = {div_rem_r[32:0], div_num_r[61]};
    dv_ge    = (dv_rem2 >= {1'b0, s_r});
    dv_diff  = dv_rem2 - {1'b0, s_r};
    dv_q_nxt = {div_q_r[60:0], dv_ge};
    if (div_neg_r) begin
      dv_word = (dv_q_nxt > 62'd2147483648) ? WMIN : -word_t'(dv_q_nxt[W-1:0]);
    end else begin
      dv_word = (dv_q_nxt > 62'd2147483647) ? WMAX : word_t'(dv_q_nxt[W-1:0]);
    end
    dl_mag = row_rd[W-1] ? 32'(-row_rd) : 32'(row_rd);
    dl_num = {dl_mag, 30'b0} + {30'b0, s_r[32:1]};
  end

  always_comb begin
    wide = 1'b0;
    for (int i = 0; i < NE; i++) begin
      if (!((&v_r[i][VW-1:W-1]) || !(|v_r[i][VW-1:W-1]))) begin
        wide = 1'b1;
      end
    end
  end

  always_comb begin
    emit_data = '0;
    if (!deg_r) begin
      for (int i = 0; i < NE; i++) begin
        case (erow_r)
          ROW0:    emit_data[i*W +: W] = u_r[i];
          ROW1:    emit_data[i*W +: W] = v_r[i][W-1:0];
          default: emit_data[i*W +: W] = w_r[i];
        endcase
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          state_nxt = item.r0_zero ? ST_EMIT : ST_MAC;
        end
      end
      ST_MAC: begin
        if (phase_r == 2'd2 && last_step) begin
          unique case (kind_r)
            MK_SQ:   state_nxt = n_zero ? ST_EMIT : ST_SQRT;
            MK_PR:   state_nxt = ST_MAC;
            MK_UP:   state_nxt = ST_RED;
            default: state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_SQRT:  if (sq_cnt_r == 5'd31) state_nxt = ST_DLOAD;
      ST_DLOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_cnt_r == 6'd61) begin
          state_nxt = (k_r == 3'd5) ? ST_MAC : ST_DLOAD;
        end
      end
      ST_RED:   if (!wide) state_nxt = ST_MAC;
      ST_EMIT:  if (emit_load && erow_r == ROW2) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    item_pop  = (state_r == ST_IDLE) && item_valid;
    emit_load = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data_r <= emit_data;
      out_user_r <= {deg_r, erow_r};
      out_last_r <= (erow_r == ROW2);
      erow_r     <= erow_r + 2'd1;
    end
    unique case (state_r)
      ST_IDLE: begin
        erow_r    <= ROW0;
        kind_r    <= MK_SQ;
        step_r    <= '0;
        phase_r   <= '0;
        row_sel_r <= 1'b0;
        deg_r     <= item.r0_zero;
        for (int i = 0; i < NE; i++) begin
          u_r[i] <= item.r0[i];
          v_r[i] <= {{(VW-W){item.r1[i][W-1]}}, item.r1[i]};
        end
      end
      ST_MAC: begin
        unique case (phase_r)
          2'd0: begin
            prod_r  <= mul_p;
            phase_r <= 2'd1;
          end
          2'd1: begin
            acc_r <= acc_sum;
            if (grp_end) begin
              phase_r <= 2'd2;
            end else begin
              phase_r <= 2'd0;
              step_r  <= step_r + 5'd1;
            end
          end
          default: begin
            phase_r <= 2'd0;
            step_r  <= last_step ? 5'd0 : step_r + 5'd1;
            unique case (kind_r)
              MK_SQ: begin
                deg_r     <= n_zero;
                sq_op_r   <= n_big ? acc_r[65:2] : acc_r[63:0];
                sq_dbl_r  <= n_big;
                sq_rem_r  <= '0;
                sq_root_r <= '0;
                sq_cnt_r  <= '0;
              end
              MK_PR: begin
                if (pgrp) begin
                  ai_r <= r28[AW-1:0];
                end else begin
                  ar_r <= r28[AW-1:0];
                end
                if (last_step) begin
                  kind_r <= MK_UP;
                end
              end
              MK_UP: begin
                v_r[step_r[3:1]] <= v_r[step_r[3:1]] - r30[VW-1:0];
              end
              default: begin
                w_r[step_r[4:2]] <= cw;
              end
            endcase
          end
        endcase
      end
      ST_SQRT: begin
        sq_rem_r  <= sq_ge ? sq_diff[33:0] : sq_rem2[33:0];
        sq_root_r <= sq_root_nxt;
        sq_op_r   <= {sq_op_r[61:0], 2'b00};
        sq_cnt_r  <= sq_cnt_r + 5'd1;
        s_r       <= sq_dbl_r ? {sq_root_nxt, 1'b0} : {1'b0, sq_root_nxt};
        k_r       <= '0;
      end
      ST_DLOAD: begin
        div_num_r <= dl_num;
        div_neg_r <= row_rd[W-1];
        div_rem_r <= '0;
        div_q_r   <= '0;
        div_cnt_r <= '0;
      end
      ST_DIV: begin
        div_rem_r <= dv_ge ? dv_diff : dv_rem2;
        div_q_r   <= dv_q_nxt;
        div_num_r <= {div_num_r[60:0], 1'b0};
        div_cnt_r <= div_cnt_r + 6'd1;
        if (div_cnt_r == 6'd61) begin
          if (row_sel_r) begin
            v_r[k_r] <= {{(VW-W){dv_word[W-1]}}, dv_word};
          end else begin
            u_r[k_r] <= dv_word;
          end
          k_r <= k_r + 3'd1;
          if (k_r == 3'd5) begin
            kind_r  <= row_sel_r ? MK_CR : MK_PR;
            step_r  <= '0;
            phase_r <= '0;
          end
        end
      end
      ST_RED: begin
        if (wide) begin
          for (int i = 0; i < NE; i++) begin
            v_r[i] <= v_r[i] >>> 1;
          end
        end else begin
          row_sel_r <= 1'b1;
          kind_r    <= MK_SQ;
          step_r    <= '0;
          phase_r   <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import su3r_pkg::*;

  typedef logic signed [127:0] wide_t;

  // one expected row of the rebuilt matrix
  typedef struct {
    logic [1:0] row;
    logic       last;
    logic       deg;
    word_t      col [NE];
  } unit_row_t;

  localparam int WATCHDOG_LIMIT = 40000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [383:0] in_tdata;    // r0c0_re, r0c0_im, .. r0c2_im, r1c0_re, .. r1c2_im
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;   // col0_re, col0_im, col1_re, col1_im, col2_re, col2_im
  logic [2:0]   out_tuser;   // row_number[1:0], degenerate
  logic         out_tlast;

  unit_row_t pending_rows [$];
  int        err_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_cycles;
  int        quiet_cycles;

  su3_matrix_reunitarize_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // ---------------------------------------------------------------------------
  // fixed-point predictor, all intermediate math in 128-bit signed
  // ---------------------------------------------------------------------------
  function automatic wide_t round_up_shift(wide_t x, int n);
    round_up_shift = (x + (wide_t'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic wide_t sat_word(wide_t x);
    if (x > wide_t'(WMAX)) sat_word = wide_t'(WMAX);
    else if (x < wide_t'(WMIN)) sat_word = wide_t'(WMIN);
    else sat_word = x;
  endfunction

  function automatic wide_t int_sqrt(wide_t n_in);
    wide_t n, r, b;
    n = n_in;
    r = 0;
    b = wide_t'(1) <<< 64;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    int_sqrt = r;
  endfunction

  // scale six words to unit norm, returns 0 when the norm is zero
  function automatic bit unit_scale(inout wide_t x [NE]);
    wide_t nsq, s, m, q;
    nsq = 0;
    foreach (x[k]) nsq = nsq + x[k] * x[k];
    if (nsq == 0) return 1'b0;
    if (nsq < (wide_t'(1) <<< 62)) s = int_sqrt(nsq);
    else s = 2 * int_sqrt(nsq >>> 2);
    foreach (x[k]) begin
      m = x[k] <<< 30;
      if (m < 0) m = -m;
      // round half away from zero
      q = (m + (s >>> 1)) / s;
      x[k] = sat_word(x[k] < 0 ? -q : q);
    end
    return 1'b1;
  endfunction

  // work out the three rows for one matrix and queue them
  task automatic predict_unitary(input word_t r [12]);
    wide_t u [NE], v [NE], w [NE];
    wide_t ar, ai, ur, ui, vr, vi, re, im;
    bit ok, wide_v;
    int a, b;
    unit_row_t res;
    for (int k = 0; k < NE; k++) begin
      u[k] = r[k];
      v[k] = r[NE + k];
    end
    ok = unit_scale(u);
    if (ok) begin
      // projection coefficient of row 1 onto unit row 0
      ar = 0;
      ai = 0;
      for (int k = 0; k < 3; k++) begin
        ur = u[2*k]; ui = u[2*k+1]; vr = v[2*k]; vi = v[2*k+1];
        ar = ar + ((ur * vr) >>> 2) + ((ui * vi) >>> 2);
        ai = ai + ((ur * vi) >>> 2) - ((ui * vr) >>> 2);
      end
      ar = round_up_shift(ar, 28);
      ai = round_up_shift(ai, 28);
      for (int k = 0; k < 3; k++) begin
        ur = u[2*k]; ui = u[2*k+1];
        v[2*k]   = v[2*k]   - round_up_shift(ar * ur - ai * ui, 30);
        v[2*k+1] = v[2*k+1] - round_up_shift(ar * ui + ai * ur, 30);
      end
      // bring the reduced row back into word range
      do begin
        wide_v = 1'b0;
        foreach (v[k]) if (v[k] > wide_t'(WMAX) || v[k] < wide_t'(WMIN)) wide_v = 1'b1;
        if (wide_v) foreach (v[k]) v[k] = v[k] >>> 1;
      end while (wide_v);
      ok = unit_scale(v);
    end
    if (!ok) begin
      foreach (u[k]) begin
        u[k] = 0; v[k] = 0; w[k] = 0;
      end
    end else begin
      // conjugate cross product
      for (int k = 0; k < 3; k++) begin
        a = (k + 1) % 3;
        b = (k + 2) % 3;
        re = u[2*a] * v[2*b] - u[2*a+1] * v[2*b+1] - u[2*b] * v[2*a] + u[2*b+1] * v[2*a+1];
        im = u[2*a] * v[2*b+1] + u[2*a+1] * v[2*b] - u[2*b] * v[2*a+1] - u[2*b+1] * v[2*a];
        w[2*k]   = sat_word(round_up_shift(re, 30));
        w[2*k+1] = sat_word(-round_up_shift(im, 30));
      end
    end
    for (int rr = 0; rr < 3; rr++) begin
      res.row  = (rr == 0) ? ROW0 : (rr == 1) ? ROW1 : ROW2;
      res.last = (rr == 2);
      res.deg  = !ok;
      for (int k = 0; k < NE; k++)
        res.col[k] = word_t'((rr == 0) ? u[k] : (rr == 1) ? v[k] : w[k]);
      pending_rows.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender: one matrix per call, valid stays high between back-to-back transfers
  // ---------------------------------------------------------------------------
  task automatic send_matrix(input word_t r [12]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    for (int k = 0; k < 12; k++) in_tdata[32*k +: 32] <= r[k];
    do @(posedge clk); while (!in_tready);
    predict_unitary(r);
  endtask

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker, compares each transfer with the oldest expected row
  always @(posedge clk) begin
    unit_row_t want;
    bit bad;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_rows.size() == 0) begin
        err_count = err_count + 1;
        if (err_count <= 10) $display("unexpected row transfer: tdata=%h tuser=%b tlast=%b",
                                      out_tdata, out_tuser, out_tlast);
      end else begin
        want = pending_rows.pop_front();
        bad = (out_tuser[1:0] != want.row) || (out_tuser[2] != want.deg) ||
              (out_tlast != want.last);
        for (int k = 0; k < NE; k++) if (out_tdata[32*k +: 32] != want.col[k]) bad = 1'b1;
        if (bad) begin
          err_count = err_count + 1;
          if (err_count <= 10) begin
            $display("row mismatch: exp row=%0d last=%b deg=%b cols=%h %h %h %h %h %h",
                     want.row, want.last, want.deg, want.col[0], want.col[1], want.col[2],
                     want.col[3], want.col[4], want.col[5]);
            $display("              got row=%0d last=%b deg=%b cols=%h %h %h %h %h %h",
                     out_tuser[1:0], out_tlast, out_tuser[2], out_tdata[31:0],
                     out_tdata[63:32], out_tdata[95:64], out_tdata[127:96],
                     out_tdata[159:128], out_tdata[191:160]);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic word_t rand_word(int kind);
    case (kind)
      0:       rand_word = word_t'($urandom);
      1:       rand_word = word_t'($urandom_range(32'h3fffffff)) - 32'sh20000000;
      default: rand_word = word_t'($urandom_range(4095)) - 32'sd2048;
    endcase
  endfunction

  task automatic test_directed();
    word_t r [12];
    // all zero: degenerate
    foreach (r[k]) r[k] = 0;
    send_matrix(r);
    // identity rows
    foreach (r[k]) r[k] = 0;
    r[0] = 32'sh40000000; r[8] = 32'sh40000000;
    send_matrix(r);
    // row 1 parallel to row 0, reduces to zero
    foreach (r[k]) r[k] = 0;
    r[0] = 32'sh40000000; r[6] = 32'sh20000000;
    send_matrix(r);
    // row 1 zero
    foreach (r[k]) r[k] = (k < NE) ? 32'sh10000000 : 0;
    send_matrix(r);
    // row 1 equal to row 0
    foreach (r[k]) r[k] = (k < NE) ? word_t'(32'sh12345678 * (k + 1)) : 32'sh0;
    for (int k = 0; k < NE; k++) r[NE + k] = r[k];
    send_matrix(r);
    // extremes of the word range
    foreach (r[k]) r[k] = WMAX;
    send_matrix(r);
    foreach (r[k]) r[k] = WMIN;
    send_matrix(r);
    foreach (r[k]) r[k] = k[0] ? WMIN : WMAX;
    send_matrix(r);
    foreach (r[k]) r[k] = (k < NE) ? WMIN : WMAX;
    send_matrix(r);
    foreach (r[k]) r[k] = (k < NE) ? WMAX : -32'sd1;
    send_matrix(r);
    // tiny magnitudes
    foreach (r[k]) r[k] = k[0] ? -32'sd1 : 32'sd1;
    send_matrix(r);
    foreach (r[k]) r[k] = 0;
    r[5] = 32'sd1; r[11] = -32'sd1; r[6] = 32'sd1;
    send_matrix(r);
    // large row 0, tiny row 1 and the reverse
    foreach (r[k]) r[k] = (k < NE) ? WMAX : 32'sd3;
    send_matrix(r);
    foreach (r[k]) r[k] = (k < NE) ? 32'sd2 : WMIN;
    send_matrix(r);
    // imaginary-only rows
    foreach (r[k]) r[k] = k[0] ? 32'sh30000000 : 32'sh0;
    r[7] = -32'sh30000000;
    send_matrix(r);
  endtask

  task automatic test_random(input int n_items);
    word_t r [12];
    int pick, kind, sh;
    repeat (n_items) begin
      pick = $urandom_range(99);
      kind = $urandom_range(2);
      foreach (r[k]) r[k] = rand_word(kind);
      if (pick < 40) begin
        // random entries of magnitude up to one half in every word
        foreach (r[k]) r[k] = rand_word(1);
      end else if (pick < 50) begin
        // zero row 0
        for (int k = 0; k < NE; k++) r[k] = 0;
      end else if (pick < 58) begin
        // row 1 a power-of-two multiple of row 0
        sh = $urandom_range(3);
        for (int k = 0; k < NE; k++) begin
          r[k] = rand_word(2);
          r[NE + k] = r[k] <<< sh;
        end
      end else if (pick < 63) begin
        // row 1 zero
        for (int k = NE; k < 12; k++) r[k] = 0;
      end else if (pick < 68) begin
        // saturated entries mixed in
        foreach (r[k]) if ($urandom_range(1)) r[k] = $urandom_range(1) ? WMAX : WMIN;
      end
      send_matrix(r);
    end
  endtask

  // receiver holds off while the sender keeps offering, the queue fills up
  task automatic test_backpressure();
    hold_cycles = 3000;
    test_random(8);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    err_count      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    quiet_cycles   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(50);
    send_idle_pct = 61;
    test_random(50);
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    test_random(50);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    test_random(50);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_backpressure();
    drain_results();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
src/su3r_pkg.sv
src/su3r_front.sv
src/su3r_back.sv
src/su3_matrix_reunitarize_core.sv
verif/tb_top.sv
